// ----- rtl/core/mavor_pkg.sv -----
// Shared types, widths and register codes for the moving-average outlier filter.
package mavor_pkg;

	// Default ring depth handed to the top level.
	localparam int DEF_WINDOW = 16;

	// Fixed field widths.
	localparam int SAMPLE_W  = 16;
	localparam int OUT_W     = 17;
	localparam int RATE_W    = 16;
	localparam int OFFSET_W  = 16;
	localparam int TOL_SHIFT = 12;

	// Configuration port geometry.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_FILTER_ENABLE  = 2'd0;
	localparam logic [1:0] REG_RATE_TOLERANCE = 2'd1;
	localparam logic [1:0] REG_VALUE_OFFSET   = 2'd2;

	// Input word.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sample_invalid;
	} in_word_t;

	// Output word.
	typedef struct packed {
		logic signed [OUT_W-1:0] corrected_value;
		logic                    accepted;
	} out_word_t;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic                       filter_enable;
		logic [RATE_W-1:0]          rate_tolerance;
		logic signed [OFFSET_W-1:0] value_offset;
	} cfg_t;

endpackage

// ----- rtl/core/mavor_apb_regs.sv -----
// APB configuration registers for the moving-average outlier filter.
module mavor_apb_regs
	import mavor_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FILTER_ENABLE: begin
					cfg_q.filter_enable <= pwdata[0];
				end
				REG_RATE_TOLERANCE: begin
					cfg_q.rate_tolerance <= pwdata[RATE_W-1:0];
				end
				REG_VALUE_OFFSET: begin
					cfg_q.value_offset <= $signed(pwdata[OFFSET_W-1:0]);
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (reg_idx)
			REG_FILTER_ENABLE:  prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.filter_enable};
			REG_RATE_TOLERANCE: prdata = {{(APB_DATA_W-RATE_W){1'b0}}, cfg_q.rate_tolerance};
			REG_VALUE_OFFSET:   prdata = {{(APB_DATA_W-OFFSET_W){1'b0}}, cfg_q.value_offset};
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/mavor_ring.sv -----
// History ring: single-port synchronous memory, read-before-write, registered read.
module mavor_ring
	import mavor_pkg::*;
#(
	parameter int DEPTH = DEF_WINDOW,
	parameter int PTR_W = 4
) (
	input  logic                clk,
	input  logic                en,
	input  logic [PTR_W-1:0]    addr,
	input  logic [SAMPLE_W-1:0] wdata,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	// The read returns the entry being overwritten in the same cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/mavor_pipe.sv -----
// Filter pipeline: ring pointer and fill count, running sum, tolerance products, decision.
module mavor_pipe
	import mavor_pkg::*;
#(
	parameter int WINDOW = DEF_WINDOW,
	parameter int PTR_W  = 4,
	parameter int CNT_W  = 5,
	parameter int SUM_W  = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_word_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_word_t           out_data,
	output logic                ring_en,
	output logic [PTR_W-1:0]    ring_addr,
	output logic [SAMPLE_W-1:0] ring_wdata,
	input  logic [SAMPLE_W-1:0] ring_rdata
);

	localparam int PROD_W = SUM_W + RATE_W + 1;
	localparam int TOL_W  = PROD_W - TOL_SHIFT;
	localparam int CMP_W  = TOL_W + 1;
	localparam int LHS_W  = SAMPLE_W + CNT_W + 1;

	// Handshake enables, one per stage, and stage 0 control signals.
	logic en1, en2, en3, en_out, acc, chk0, full0;
	logic [CNT_W-1:0] n0;

	// Stage 0 state.
	logic [PTR_W-1:0] pos_q;
	logic [CNT_W-1:0] fill_q;
	logic signed [SUM_W-1:0] sum_q;

	// Stage 1.
	logic                       v_s1, chk_s1, ok_s1, full_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [CNT_W-1:0]           n_s1;
	logic signed [SUM_W-1:0]    new_sum;

	// Stage 2.
	logic                       v_s2, chk_s2, ok_s2;
	logic signed [SAMPLE_W-1:0] x_s2;
	logic [CNT_W-1:0]           n_s2;
	logic signed [SUM_W-1:0]    sum_s2;

	// Stage 3.
	logic                       v_s3, chk_s3, ok_s3;
	logic signed [SAMPLE_W-1:0] x_s3;
	logic signed [SUM_W-1:0]    sum_s3;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [LHS_W-1:0]    lhs_s3;

	// Decision.
	logic signed [TOL_W-1:0] tol;
	logic signed [CMP_W-1:0] lo, hi, lhs_x, sum_x, tol_x;
	logic                    pass;
	logic                    out_valid_q;
	out_word_t               out_q;

	// Each stage moves when it is empty or the one after it moves.
	assign en_out   = !out_valid_q || !out_stall;
	assign en3      = !v_s3 || en_out;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign acc      = in_valid && en1;

	// Only valid samples with the filter on touch the ring.
	assign chk0  = !in_data.sample_invalid && cfg.filter_enable;
	assign full0 = (fill_q == CNT_W'(WINDOW));
	assign n0    = full0 ? fill_q : fill_q + 1'b1;

	assign ring_en    = acc && chk0;
	assign ring_addr  = pos_q;
	assign ring_wdata = in_data.sample;

	// Write pointer and fill count advance as a checked sample enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (ring_en) begin
			pos_q  <= (pos_q == PTR_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
			fill_q <= n0;
		end
	end

	// Stage 1 capture; the ring read data arrives alongside.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1    <= in_data.sample;
			chk_s1  <= chk0;
			ok_s1   <= !in_data.sample_invalid;
			full_s1 <= full0;
			n_s1    <= n0;
		end
	end

	// Running sum: drop the overwritten entry once full, add the new sample.
	always_comb begin
		new_sum = sum_q + SUM_W'(x_s1);
		if (full_s1) begin
			new_sum = new_sum - SUM_W'($signed(ring_rdata));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en2 && v_s1 && chk_s1) begin
			sum_q <= new_sum;
		end
	end

	// Stage 2 capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sum_s2 <= new_sum;
			x_s2   <= x_s1;
			n_s2   <= n_s1;
			chk_s2 <= chk_s1;
			ok_s2  <= ok_s1;
		end
	end

	// Stage 3: tolerance product and scaled sample, both registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'($signed({1'b0, cfg.rate_tolerance}));
			lhs_s3  <= LHS_W'(x_s2) * LHS_W'($signed({1'b0, n_s2}));
			sum_s3  <= sum_s2;
			x_s3    <= x_s2;
			chk_s3  <= chk_s2;
			ok_s3   <= ok_s2;
		end
	end

	// Floor shift of the product, then the band check around the sum.
	always_comb begin
		tol   = prod_s3[PROD_W-1:TOL_SHIFT];
		tol_x = CMP_W'(tol);
		sum_x = CMP_W'(sum_s3);
		lhs_x = CMP_W'(lhs_s3);
		lo    = sum_x - tol_x;
		hi    = sum_x + tol_x;
		pass  = !chk_s3 || !((lhs_x < lo) || (lhs_x > hi));
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q.accepted <= ok_s3 && pass;
			if (ok_s3 && pass) begin
				out_q.corrected_value <= OUT_W'(x_s3) + OUT_W'(cfg.value_offset);
			end else begin
				out_q.corrected_value <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/core/moving_average_outlier_reject_core.sv -----
// Each accepted word passes stage 1, stage 2, stage 3 and the output register.
// One word per cycle unless stalled; a checked word reads and writes one ring address.
// Back-pressure ripples stage by stage, so bubbles are filled while the output is held.
// Reset (arst_n low): pointer, fill count, running sum, registers and valids clear.
// History memory is not cleared; a read entry is only used once it has been written.
module moving_average_outlier_reject_core
	import mavor_pkg::*;
#(
	parameter int WINDOW = DEF_WINDOW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_data
);

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

	cfg_t                cfg;
	logic                ring_en;
	logic [PTR_W-1:0]    ring_addr;
	logic [SAMPLE_W-1:0] ring_wdata;
	logic [SAMPLE_W-1:0] ring_rdata;

	assign pready = 1'b1;

	// Configuration registers.
	mavor_apb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// History memory.
	mavor_ring #(
		.DEPTH(WINDOW),
		.PTR_W(PTR_W)
	) u_ring (
		.clk  (clk),
		.en   (ring_en),
		.addr (ring_addr),
		.wdata(ring_wdata),
		.rdata(ring_rdata)
	);

	// Filter pipeline.
	mavor_pipe #(
		.WINDOW(WINDOW),
		.PTR_W (PTR_W),
		.CNT_W (CNT_W),
		.SUM_W (SUM_W)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.ring_en   (ring_en),
		.ring_addr (ring_addr),
		.ring_wdata(ring_wdata),
		.ring_rdata(ring_rdata)
	);

endmodule

// ----- rtl/core/mavor_checker.sv -----
// Port-level checks for the moving-average outlier filter, bound to the top level.
module mavor_checker
	import mavor_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	// While reset is held, the output register is empty from the next edge on.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output word valid during reset");

	// A held output word stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	// A rejected word carries a zero value.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |-> out_data.corrected_value == '0)
		else $error("rejected word with non-zero value");

	// The input is only held back when the full pipeline is blocked at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind moving_average_outlier_reject_core mavor_checker u_mavor_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

// ----- tb/moving_average_outlier_reject_core_tb.sv -----
// Self-checking testbench for the moving-average outlier rejection core.
module moving_average_outlier_reject_core_tb;
	import mavor_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 6;
	localparam int MAX_REPORTS = 200;
	// Spare register slot that decodes to nothing.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Scoreboard: keeps a copy of the filter state and the register values and
	// queues the output word that each accepted input word should produce.
	class outlier_scoreboard;
		bit              enable;
		longint          rate;
		longint          offset;
		longint          ring[DEF_WINDOW];
		int              wpos;
		int              fill;
		longint          sum;
		out_word_t       awaited[$];
		int              mismatches;

		function void set_register(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
			logic signed [OFFSET_W-1:0] off;
			off = value[OFFSET_W-1:0];
			case (idx)
				REG_FILTER_ENABLE: enable = value[0];
				REG_RATE_TOLERANCE: rate = value[RATE_W-1:0];
				REG_VALUE_OFFSET: offset = off;
				default: ;
			endcase
		endfunction

		// Runs one accepted word through the filter and queues the outcome.
		function void screen_sample(in_word_t w);
			longint    x;
			longint    tol;
			longint    lhs;
			bit        ok;
			out_word_t r;
			x = w.sample;
			ok = !w.sample_invalid;
			if (ok && enable) begin
				if (fill >= DEF_WINDOW)
					sum -= ring[wpos];
				ring[wpos] = x;
				sum += x;
				wpos = (wpos + 1) % DEF_WINDOW;
				if (fill < DEF_WINDOW)
					fill++;
				// Arithmetic shift of a signed product gives the floor.
				tol = (sum * rate) >>> TOL_SHIFT;
				lhs = x * fill;
				if (lhs < sum - tol || lhs > sum + tol)
					ok = 0;
			end
			r.accepted = ok;
			r.corrected_value = ok ? OUT_W'(x + offset) : '0;
			awaited.push_back(r);
		endfunction

		function void check_reading(out_word_t got);
			out_word_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$error("output word with nothing awaited: corrected_value %0d, accepted %0b",
						got.corrected_value, got.accepted);
				return;
			end
			want = awaited.pop_front();
			if (got.corrected_value !== want.corrected_value) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$error("corrected_value: expected %0d, got %0d",
						want.corrected_value, got.corrected_value);
			end
			if (got.accepted !== want.accepted) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_data;

	outlier_scoreboard sb = new();
	int cycles = 0;
	int stall_left = 0;

	moving_average_outlier_reject_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Output back-pressure: quiet stretches, short stalls and the odd long one.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (cycles[10:9] == 2'd0) begin
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(0, 2);
				end
				4: begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(8, 30);
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// Result monitor and watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall)
			sb.check_reading(out_data);
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Mostly back-to-back words, some short gaps and a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
		// Return to idle before the next transfer.
		@(posedge clk);
	endtask

	// Holds the sender off until every awaited word has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic configure(logic enable, logic [APB_DATA_W-1:0] rate,
		logic [APB_DATA_W-1:0] offset);
		drain();
		write_reg(REG_FILTER_ENABLE, ({$urandom} & ~32'd1) | enable);
		write_reg(REG_RATE_TOLERANCE, rate);
		write_reg(REG_VALUE_OFFSET, offset);
	endtask

	task automatic send_sample(logic signed [SAMPLE_W-1:0] value, logic invalid, int gap);
		in_word_t w;
		w.sample = value;
		w.sample_invalid = invalid;
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.screen_sample(w);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int base;
		int spread;
		int kind;
		logic enable;
		logic [APB_DATA_W-1:0] rate;
		logic [APB_DATA_W-1:0] offset;
		logic signed [SAMPLE_W-1:0] value;

		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Filter off after reset: extremes pass straight through, invalid ones do not.
		send_sample(16'sh7FFF, 1'b0, pick_gap());
		send_sample(16'sh8000, 1'b0, pick_gap());
		send_sample(16'sh0000, 1'b0, pick_gap());
		send_sample(16'shFFFF, 1'b0, pick_gap());
		send_sample(16'sh5555, 1'b1, pick_gap());
		send_sample(16'shAAAA, 1'b1, pick_gap());

		// A write to the spare slot must leave every register alone.
		drain();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);

		// Offset extremes give the widest outputs.
		configure(1'b0, 32'd0, 32'h0000_7FFF);
		send_sample(16'sh7FFF, 1'b0, pick_gap());
		send_sample(16'sh8000, 1'b0, pick_gap());
		configure(1'b0, 32'd0, 32'hFFFF_8000);
		send_sample(16'sh8000, 1'b0, pick_gap());
		send_sample(16'sh7FFF, 1'b0, pick_gap());

		// Zero tolerance: only a sample equal to the average survives.
		configure(1'b1, 32'd0, 32'd0);
		send_sample(16'sd100, 1'b0, pick_gap());
		send_sample(16'sd100, 1'b0, pick_gap());
		send_sample(16'sd101, 1'b0, pick_gap());
		send_sample(16'sd5000, 1'b1, pick_gap());
		send_sample(16'sd100, 1'b0, pick_gap());

		// Widest tolerance with negative and extreme samples.
		configure(1'b1, 32'd65535, 32'd0);
		send_sample(-16'sd200, 1'b0, pick_gap());
		send_sample(-16'sd200, 1'b0, pick_gap());
		send_sample(16'sh7FFF, 1'b0, pick_gap());
		send_sample(16'sh8000, 1'b0, pick_gap());

		// Moderate tolerance and an offset, with the earlier history still in the ring.
		configure(1'b1, 32'd512, 32'd1000);
		send_sample(16'sd1000, 1'b0, pick_gap());
		send_sample(16'sd1050, 1'b0, pick_gap());
		send_sample(16'sd980, 1'b0, pick_gap());
		send_sample(16'sd3000, 1'b0, pick_gap());
		send_sample(16'sd0, 1'b0, pick_gap());

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < 8; phase++) begin
			enable = (phase == 2) ? 1'b0 : ($urandom_range(0, 5) != 0);
			case ($urandom_range(0, 4))
				0: rate = 32'd0;
				1: rate = 32'd65535;
				4: rate = $urandom;
				default: rate = $urandom_range(64, 1024);
			endcase
			case ($urandom_range(0, 3))
				0: offset = 32'h0000_7FFF;
				1: offset = 32'hFFFF_8000;
				default: offset = $urandom;
			endcase
			configure(enable, rate, offset);

			base = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 20000))
				: int'($urandom_range(200, 20000));
			spread = $urandom_range(0, 600);
			for (int k = 0; k < 120; k++) begin
				// Pause once per phase until the pipeline has emptied.
				if (k == 60)
					drain();
				if (k % 40 == 39)
					base += int'($urandom_range(0, 400)) - 200;
				kind = $urandom_range(0, 99);
				if (kind < 70)
					send_sample(SAMPLE_W'(base + int'($urandom_range(0, 2 * spread)) - spread),
						1'b0, (phase % 2 == 1 && k < 60) ? 0 : pick_gap());
				else if (kind < 80)
					send_sample(SAMPLE_W'(base + (($urandom_range(0, 1) == 1) ? 9000 : -9000)),
						1'b0, pick_gap());
				else if (kind < 88)
					send_sample(SAMPLE_W'($urandom), 1'b1, pick_gap());
				else begin
					value = SAMPLE_W'($urandom);
					send_sample(value, 1'($urandom_range(0, 1)), pick_gap());
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
